### src/tcs_pkg.sv
// Telnet command stripper: shared types and telnet command codes.
// No dependencies; used by tcs_decoder and telnet_command_stripper_unit.
package tcs_pkg;

   // Telnet command bytes
   localparam logic [7:0] IAC  = 8'd255;
   localparam logic [7:0] DONT = 8'd254;
   localparam logic [7:0] DO   = 8'd253;
   localparam logic [7:0] WONT = 8'd252;
   localparam logic [7:0] WILL = 8'd251;
   localparam logic [7:0] SB   = 8'd250;
   localparam logic [7:0] GA   = 8'd249;
   localparam logic [7:0] EC   = 8'd247;
   localparam logic [7:0] AYT  = 8'd246;
   localparam logic [7:0] NOP  = 8'd241;
   localparam logic [7:0] SE   = 8'd240;
   localparam logic [7:0] BACKSPACE = 8'h08;

   // Destination of a result
   localparam logic DEST_TERMINAL = 1'b0;
   localparam logic DEST_PEER     = 1'b1;

   typedef enum logic [1:0] {
      PH_DATA   = 2'd0,
      PH_IAC    = 2'd1,
      PH_OPTION = 2'd2
   } phase_type;

   // Outcome of one received byte
   typedef struct packed {
      phase_type  next_phase;
      logic       next_sub;
      logic       emit;
      logic       dest_kind;
      logic [7:0] out_byte;
   } step_type;

endpackage

### src/tcs_decoder.sv
// Telnet command stripper: per-byte parser decision (next state and result).
// Depends on tcs_pkg.
module tcs_decoder (
   input  tcs_pkg::phase_type phase,
   input  logic               in_sub,
   input  logic [7:0]         rx_byte,
   output tcs_pkg::step_type  step
);
   import tcs_pkg::*;

   always_comb begin
      step            = '0;
      step.next_phase = PH_DATA;
      step.next_sub   = in_sub;
      step.emit       = 1'b0;
      step.dest_kind  = DEST_TERMINAL;
      step.out_byte   = rx_byte;
      case (phase)
         PH_OPTION: begin
            // option byte swallowed, whatever it is
         end
         PH_IAC: begin
            if (in_sub && (rx_byte != SE)) begin
               step.emit      = 1'b1;
               step.dest_kind = DEST_PEER;
            end else begin
               case (rx_byte)
                  IAC: begin
                     step.emit = 1'b1;
                  end
                  WILL, WONT, DO, DONT: begin
                     step.next_phase = PH_OPTION;
                  end
                  SB: begin
                     step.next_sub = 1'b1;
                  end
                  SE: begin
                     step.next_sub = 1'b0;
                  end
                  EC: begin
                     step.emit     = 1'b1;
                     step.out_byte = BACKSPACE;
                  end
                  NOP, GA, AYT: begin
                     // known commands with no effect here
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
            if (rx_byte == IAC) begin
               step.next_phase = PH_IAC;
            end else if (!in_sub) begin
               step.emit = 1'b1;
            end
         end
      endcase
   end

endmodule

### src/telnet_command_stripper_unit.sv
// Telnet command stripper, top level: request/result handshakes, parser state.
// A kept byte appears on rsp_ in the cycle after its request is taken.
// Throughput: one request per cycle; a single output register parts the sides,
// so req_ready is low only while a result waits and rsp_ready is low.
// Reset (synchronous, active high): plain data phase, out of subnegotiation,
// output register empty.
module telnet_command_stripper_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_dest_kind,
   output logic [7:0] rsp_out_byte
);
   import tcs_pkg::*;

   // Parser state
   phase_type  phase_ff, phase_in;
   logic       sub_ff, sub_in;

   // Result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;

   step_type   step;
   logic       req_fire;

   // Room in the result register if empty or being drained this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   tcs_decoder u_decoder (
      .phase   (phase_ff),
      .in_sub  (sub_ff),
      .rx_byte (req_rx_byte),
      .step    (step)
   );

   // Next state and result register loading
   always_comb begin
      phase_in     = phase_ff;
      sub_in       = sub_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         phase_in = step.next_phase;
         sub_in   = step.next_sub;
         if (step.emit) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = step.dest_kind;
            rsp_byte_in  = step.out_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DATA;
         sub_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_dest_kind = rsp_kind_ff;
   assign rsp_out_byte  = rsp_byte_ff;

   // Option phase is only entered from outside subnegotiation
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_OPTION) |-> !sub_ff)
      else $error("option phase reached inside subnegotiation");

   // A pending reply to the peer implies we are still in subnegotiation
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == DEST_PEER)) |-> sub_ff)
      else $error("peer reply pending outside subnegotiation");

   // Plain data outside subnegotiation passes straight through
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && (phase_ff == PH_DATA) && !sub_ff && (req_rx_byte != IAC))
      |=> (rsp_valid_ff && (rsp_kind_ff == DEST_TERMINAL)
           && (rsp_byte_ff == $past(req_rx_byte))))
      else $error("data byte not passed through");

   // Nothing taken while a stalled result still waits
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken over a stalled result");

endmodule

### tb/telnet_command_stripper_unit_tb.sv
// Testbench for telnet_command_stripper_unit: random and directed byte streams,
// checked against a behavioural parser kept alongside. Depends on tcs_pkg.
module telnet_command_stripper_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcs_pkg::*;

   // One expected result: where it goes and which byte it carries
   typedef struct packed {
      logic       dest_kind;
      logic [7:0] out_byte;
   } stripped_byte_type;

   localparam logic [7:0] VERBS [4] = '{WILL, WONT, DO, DONT};
   localparam logic [7:0] CMDS  [6] = '{NOP, GA, AYT, EC, SE, SB};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_dest_kind;
   logic [7:0] rsp_out_byte;

   // Byte stream still to be offered, and results owed by the block
   logic [7:0]        rx_stream [$];
   stripped_byte_type owed_bytes [$];

   // Shadow of the parser state
   phase_type parse_phase = PH_DATA;
   logic      in_subneg   = 1'b0;

   int  req_wait = 0;
   int  rsp_wait = 0;
   bit  req_calm = 1'b0;
   bit  rsp_calm = 1'b0;
   int  bytes_sent = 0;
   int  to_terminal = 0;
   int  to_peer = 0;
   int  errors = 0;

   telnet_command_stripper_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_dest_kind (rsp_dest_kind),
      .rsp_out_byte  (rsp_out_byte)
   );

   always #5 clock = ~clock;

   // Idle cycles before the next request or result; now and then a side
   // switches into a calm stretch where it never idles.
   function automatic int draw_wait(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = !calm;
      return calm ? 0 : int'($urandom_range(0, 9));
   endfunction

   task automatic owe_byte(input logic kind, input logic [7:0] value);
      stripped_byte_type r;
      r.dest_kind = kind;
      r.out_byte  = value;
      owed_bytes.push_back(r);
   endtask

   // Advance the shadow parser by one received byte and note any result.
   task automatic strip_byte(input logic [7:0] b);
      phase_type ph;
      ph = parse_phase;
      parse_phase = PH_DATA;
      case (ph)
         PH_OPTION: ;   // option byte of a verb: always swallowed, IAC too
         PH_IAC: begin
            // inside subnegotiation every command but SE is bounced back
            if (in_subneg && b != SE) begin
               owe_byte(DEST_PEER, b);
            end else begin
               case (b)
                  IAC:                  owe_byte(DEST_TERMINAL, IAC);
                  WILL, WONT, DO, DONT: parse_phase = PH_OPTION;
                  SB:                   in_subneg = 1'b1;
                  SE:                   in_subneg = 1'b0;
                  EC:                   owe_byte(DEST_TERMINAL, BACKSPACE);
                  default: ;            // NOP, GA, AYT and unknown: dropped
               endcase
            end
         end
         default: begin
            // plain data; the spare phase code behaves the same way
            if (b == IAC) begin
               parse_phase = PH_IAC;
            end else if (!in_subneg) begin
               owe_byte(DEST_TERMINAL, b);
            end
         end
      endcase
   endtask

   // Request side: records each accepted byte, then offers the next one after
   // its drawn gap. Valid stays high straight into the next byte when no gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'h00;
      end else begin
         if (req_valid && req_ready) begin
            strip_byte(req_rx_byte);
            bytes_sent++;
         end
         if (!req_valid || req_ready) begin
            if (req_wait > 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (rx_stream.size() > 0) begin
               req_rx_byte <= rx_stream.pop_front();
               req_valid   <= 1'b1;
               req_wait = draw_wait(req_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result side: compares each taken result with the oldest one owed, then
   // holds off ready for a drawn number of cycles.
   always @(posedge clock) begin
      stripped_byte_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_bytes.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: unexpected result dest=%0d byte=%02h",
                           $time, rsp_dest_kind, rsp_out_byte);
            end else begin
               want = owed_bytes.pop_front();
               if (want.dest_kind !== rsp_dest_kind || want.out_byte !== rsp_out_byte) begin
                  errors++;
                  if (errors <= 10)
                     $display("%0t: mismatch: expected dest=%0d byte=%02h, got dest=%0d byte=%02h",
                              $time, want.dest_kind, want.out_byte,
                              rsp_dest_kind, rsp_out_byte);
               end
            end
            if (rsp_dest_kind === DEST_PEER) to_peer++;
            else                             to_terminal++;
            rsp_wait = draw_wait(rsp_calm);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int pick;
      int body;
      logic [7:0] cmd;

      // Directed: data extremes, literal 255, erase character, verb with an
      // option (IAC as option too), a dropped command, SE with no SB open,
      // then a subnegotiation holding data and each kind of bounced command.
      rx_stream = '{8'h00, 8'hFE,
                    IAC, IAC,
                    IAC, EC,
                    IAC, WILL, 8'h01,
                    IAC, DONT, IAC,
                    IAC, NOP,
                    IAC, SE,
                    IAC, SB, 8'h55,
                    IAC, WILL,
                    IAC, SB,
                    IAC, IAC,
                    IAC, 8'h03,
                    IAC, SE};

      // Random: mostly well-formed telnet traffic, some noise and broken
      // sequences mixed in.
      while (rx_stream.size() < 780) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            rx_stream.push_back(8'($urandom_range(0, 254)));
         end else if (pick < 43) begin
            rx_stream.push_back(IAC);
            rx_stream.push_back(IAC);
         end else if (pick < 53) begin
            // known command, or now and then an unknown one
            cmd = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 239))
                                              : CMDS[$urandom_range(0, 5)];
            rx_stream.push_back(IAC);
            rx_stream.push_back(cmd);
         end else if (pick < 68) begin
            rx_stream.push_back(IAC);
            rx_stream.push_back(VERBS[$urandom_range(0, 3)]);
            rx_stream.push_back(8'($urandom_range(0, 255)));
         end else if (pick < 88) begin
            // subnegotiation with a short body of data and bounced commands
            rx_stream.push_back(IAC);
            rx_stream.push_back(SB);
            body = $urandom_range(0, 6);
            for (int i = 0; i < body; i++) begin
               if ($urandom_range(0, 4) == 0) begin
                  cmd = 8'($urandom_range(0, 255));
                  if (cmd == SE) cmd = VERBS[$urandom_range(0, 3)];
                  rx_stream.push_back(IAC);
                  rx_stream.push_back(cmd);
               end else begin
                  rx_stream.push_back(8'($urandom_range(0, 254)));
               end
            end
            rx_stream.push_back(IAC);
            rx_stream.push_back(SE);
         end else if (pick < 95) begin
            rx_stream.push_back(8'($urandom_range(0, 255)));
         end else begin
            // broken: lone IAC, or an SB that is never closed
            rx_stream.push_back(IAC);
            if ($urandom_range(0, 1) == 0) rx_stream.push_back(SB);
         end
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (rx_stream.size() != 0 || req_valid || owed_bytes.size() != 0)
         @(posedge clock);
      // keep the clock running so any stray result still shows up
      repeat (10) @(posedge clock);

      $display("Stream of %0d bytes sent; %0d results taken (%0d to terminal, %0d to peer).",
               bytes_sent, to_terminal + to_peer, to_terminal, to_peer);
      if (errors > 10) $display("%0d failures in total.", errors);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("Timeout: run did not complete.");
      $display("FAILED: results differ");
      $finish;
   end

endmodule

### files.f
src/tcs_pkg.sv
src/tcs_decoder.sv
src/telnet_command_stripper_unit.sv
tb/telnet_command_stripper_unit_tb.sv
